FILE: rtl/core/hsv2rgb_pkg.sv
// ---------------------------------------------------------------------------
// HSV to RGB converter package
// Pixel beat types, fixed-point constants and sector codes.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int HUE_FRAC_BITS = 4;
	localparam int HUE_W         = 13;
	localparam int LEVEL_W       = 8;

	localparam int SECTOR_W  = 60 << HUE_FRAC_BITS;
	localparam int FULL_TURN = 360 << HUE_FRAC_BITS;
	localparam int LEVEL_MAX = 255;
	localparam int SCALE_M   = LEVEL_MAX * SECTOR_W;

	localparam int FRAC_W  = $clog2(SECTOR_W + 1);
	localparam int SCALE_W = $clog2(SCALE_M + 1);
	localparam int SF_W    = LEVEL_W + FRAC_W;
	localparam int VP_W    = 2 * LEVEL_W;
	localparam int NUM_W   = LEVEL_W + SCALE_W;

	// floor(n / SCALE_M) == (n * RECIP) >> RECIP_SHIFT for every n below 2**NUM_W
	localparam int          RECIP_SHIFT = NUM_W + SCALE_W;
	localparam logic [63:0] RECIP       =
		((64'd1 << RECIP_SHIFT) + 64'(SCALE_M) - 64'd1) / 64'(SCALE_M);
	localparam int          RECIP_W     = RECIP_SHIFT - SCALE_W + 1;
	localparam int          MUL_W       = NUM_W + RECIP_W;

	typedef enum logic [2:0] {
		SEC_R_Y,
		SEC_Y_G,
		SEC_G_C,
		SEC_C_B,
		SEC_B_M,
		SEC_M_R
	} sector_t;

	typedef struct packed {
		logic [HUE_W-1:0]   hue;
		logic [LEVEL_W-1:0] saturation;
		logic [LEVEL_W-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} rgb_t;

endpackage

FILE: rtl/core/hsv_to_rgb_converter.sv
// Throughput: one pixel per cycle unless rgb_ready stalls it; each stage refills
// as soon as its beat moves on, so bubbles close up behind a stalled output.
// The widest step is the 26 x 27 bit reciprocal multiply in stage five.
// Reset clears the stage valid bits only; payload registers are not reset.
// ---------------------------------------------------------------------------
// HSV to RGB converter
// Six-stage pipeline: hue wrap, sector split, products, levels, scaling,
// channel select.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hsv_valid,
	output logic               hsv_ready,
	input  hsv2rgb_pkg::hsv_t  hsv,
	output logic               rgb_valid,
	input  logic               rgb_ready,
	output hsv2rgb_pkg::rgb_t  rgb
);

	localparam int HUE_W   = hsv2rgb_pkg::HUE_W;
	localparam int LEVEL_W = hsv2rgb_pkg::LEVEL_W;
	localparam int FRAC_W  = hsv2rgb_pkg::FRAC_W;
	localparam int SCALE_W = hsv2rgb_pkg::SCALE_W;
	localparam int SF_W    = hsv2rgb_pkg::SF_W;
	localparam int VP_W    = hsv2rgb_pkg::VP_W;
	localparam int NUM_W   = hsv2rgb_pkg::NUM_W;
	localparam int MUL_W   = hsv2rgb_pkg::MUL_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	logic [HUE_W-1:0]   hue_s1;
	logic [LEVEL_W-1:0] sat_s1, val_s1;

	hsv2rgb_pkg::sector_t sec_s2, sec_s3, sec_s4, sec_s5;
	logic [FRAC_W-1:0]    frac_s2;
	logic [LEVEL_W-1:0]   sat_s2, val_s2, val_s3, val_s4, val_s5;

	logic [SF_W-1:0]  sf_s3, st_s3;
	logic [VP_W-1:0]  vp_s3;

	logic [NUM_W-1:0]   nq_s4, nt_s4;
	logic [LEVEL_W-1:0] p_s4;

	logic [LEVEL_W-1:0] q_s5, t_s5, p_s5;

	hsv2rgb_pkg::rgb_t rgb_s6;

	logic [HUE_W-1:0]     hue_wrap;
	hsv2rgb_pkg::sector_t sec_d;
	logic [HUE_W-1:0]     base_d;
	logic [VP_W:0]        p_sum;
	logic [MUL_W-1:0]     q_prod, t_prod;
	hsv2rgb_pkg::rgb_t    rgb_d;

	// stage enables: a stage loads when empty or when its beat moves on
	assign en_s6     = !v_s6 || rgb_ready;
	assign en_s5     = !v_s5 || en_s6;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign hsv_ready = en_s1;
	assign rgb_valid = v_s6;
	assign rgb       = rgb_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= hsv_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// stage 1: wrap hue into one turn (input never reaches two turns)
	assign hue_wrap = (hsv.hue >= HUE_W'(hsv2rgb_pkg::FULL_TURN)) ?
		hsv.hue - HUE_W'(hsv2rgb_pkg::FULL_TURN) : hsv.hue;

	// stage 2: sector and remainder within the sector
	always_comb begin
		sec_d  = hsv2rgb_pkg::SEC_M_R;
		base_d = HUE_W'(5 * hsv2rgb_pkg::SECTOR_W);
		if (hue_s1 < HUE_W'(hsv2rgb_pkg::SECTOR_W)) begin
			sec_d  = hsv2rgb_pkg::SEC_R_Y;
			base_d = '0;
		end else if (hue_s1 < HUE_W'(2 * hsv2rgb_pkg::SECTOR_W)) begin
			sec_d  = hsv2rgb_pkg::SEC_Y_G;
			base_d = HUE_W'(hsv2rgb_pkg::SECTOR_W);
		end else if (hue_s1 < HUE_W'(3 * hsv2rgb_pkg::SECTOR_W)) begin
			sec_d  = hsv2rgb_pkg::SEC_G_C;
			base_d = HUE_W'(2 * hsv2rgb_pkg::SECTOR_W);
		end else if (hue_s1 < HUE_W'(4 * hsv2rgb_pkg::SECTOR_W)) begin
			sec_d  = hsv2rgb_pkg::SEC_C_B;
			base_d = HUE_W'(3 * hsv2rgb_pkg::SECTOR_W);
		end else if (hue_s1 < HUE_W'(5 * hsv2rgb_pkg::SECTOR_W)) begin
			sec_d  = hsv2rgb_pkg::SEC_B_M;
			base_d = HUE_W'(4 * hsv2rgb_pkg::SECTOR_W);
		end
	end

	// stage 4: p = floor(x / 255), exact for x below 65280
	assign p_sum = {1'b0, vp_s3} + (VP_W+1)'(vp_s3 >> LEVEL_W) + (VP_W+1)'(1);

	// stage 5: divide by SCALE_M through the reciprocal
	assign q_prod = MUL_W'(nq_s4) * MUL_W'(hsv2rgb_pkg::RECIP);
	assign t_prod = MUL_W'(nt_s4) * MUL_W'(hsv2rgb_pkg::RECIP);

	// stage 6: route levels to channels
	always_comb begin
		case (sec_s5)
			hsv2rgb_pkg::SEC_R_Y: rgb_d = '{red: val_s5, green: t_s5,   blue: p_s5};
			hsv2rgb_pkg::SEC_Y_G: rgb_d = '{red: q_s5,   green: val_s5, blue: p_s5};
			hsv2rgb_pkg::SEC_G_C: rgb_d = '{red: p_s5,   green: val_s5, blue: t_s5};
			hsv2rgb_pkg::SEC_C_B: rgb_d = '{red: p_s5,   green: q_s5,   blue: val_s5};
			hsv2rgb_pkg::SEC_B_M: rgb_d = '{red: t_s5,   green: p_s5,   blue: val_s5};
			default:              rgb_d = '{red: val_s5, green: p_s5,   blue: q_s5};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			hue_s1 <= hue_wrap;
			sat_s1 <= hsv.saturation;
			val_s1 <= hsv.brightness;
		end
		if (en_s2) begin
			sec_s2  <= sec_d;
			frac_s2 <= FRAC_W'(hue_s1 - base_d);
			sat_s2  <= sat_s1;
			val_s2  <= val_s1;
		end
		if (en_s3) begin
			sec_s3 <= sec_s2;
			sf_s3  <= SF_W'(sat_s2) * SF_W'(frac_s2);
			st_s3  <= SF_W'(sat_s2) *
				SF_W'(FRAC_W'(hsv2rgb_pkg::SECTOR_W) - frac_s2);
			vp_s3  <= VP_W'(val_s2) *
				VP_W'(LEVEL_W'(hsv2rgb_pkg::LEVEL_MAX) - sat_s2);
			val_s3 <= val_s2;
		end
		if (en_s4) begin
			sec_s4 <= sec_s3;
			nq_s4  <= NUM_W'(val_s3) *
				NUM_W'(SCALE_W'(hsv2rgb_pkg::SCALE_M) - SCALE_W'(sf_s3));
			nt_s4  <= NUM_W'(val_s3) *
				NUM_W'(SCALE_W'(hsv2rgb_pkg::SCALE_M) - SCALE_W'(st_s3));
			p_s4   <= p_sum[VP_W-1:LEVEL_W];
			val_s4 <= val_s3;
		end
		if (en_s5) begin
			sec_s5 <= sec_s4;
			q_s5   <= q_prod[hsv2rgb_pkg::RECIP_SHIFT +: LEVEL_W];
			t_s5   <= t_prod[hsv2rgb_pkg::RECIP_SHIFT +: LEVEL_W];
			p_s5   <= p_s4;
			val_s5 <= val_s4;
		end
		if (en_s6) begin
			rgb_s6 <= rgb_d;
		end
	end

endmodule

FILE: verif/hsv_to_rgb_converter_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives HSV beats through the valid/ready pipeline with random stalls on
// both sides. Each RGB beat is checked against an in-order queue of
// predicted colours.
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter_test;

	localparam int RANDOM_PIXELS = 450;
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct {
		hsv2rgb_pkg::hsv_t px;
		bit                settle;	// hold off until the pipeline has drained
	} hsv_job_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              hsv_valid = 1'b0;
	logic              rgb_ready = 1'b0;
	hsv2rgb_pkg::hsv_t hsv       = '0;
	logic              hsv_ready;
	logic              rgb_valid;
	hsv2rgb_pkg::rgb_t rgb;

	hsv_job_t          hsv_backlog[$];
	hsv2rgb_pkg::rgb_t rgb_due[$];
	hsv_job_t          job;
	hsv2rgb_pkg::rgb_t want;
	int                send_gap;
	int                stall_left;
	int                fail_count;
	int                cycles;

	hsv_to_rgb_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb)
	);

	always #1 clk = ~clk;

	function automatic hsv2rgb_pkg::rgb_t convert_pixel(hsv2rgb_pkg::hsv_t px);
		longint unsigned h, frac, v, s, lp, lq, lt;
		hsv2rgb_pkg::sector_t sec;
		hsv2rgb_pkg::rgb_t c;
		h    = longint'(px.hue) % hsv2rgb_pkg::FULL_TURN;
		sec  = hsv2rgb_pkg::sector_t'(h / hsv2rgb_pkg::SECTOR_W);
		frac = h % hsv2rgb_pkg::SECTOR_W;
		v    = px.brightness;
		s    = px.saturation;
		lp   = (v * (hsv2rgb_pkg::LEVEL_MAX - s)) / hsv2rgb_pkg::LEVEL_MAX;
		lq   = (v * (hsv2rgb_pkg::SCALE_M - s * frac)) / hsv2rgb_pkg::SCALE_M;
		lt   = (v * (hsv2rgb_pkg::SCALE_M - s * (hsv2rgb_pkg::SECTOR_W - frac))) /
			hsv2rgb_pkg::SCALE_M;
		case (sec)
			hsv2rgb_pkg::SEC_R_Y: {c.red, c.green, c.blue} = {8'(v), 8'(lt), 8'(lp)};
			hsv2rgb_pkg::SEC_Y_G: {c.red, c.green, c.blue} = {8'(lq), 8'(v), 8'(lp)};
			hsv2rgb_pkg::SEC_G_C: {c.red, c.green, c.blue} = {8'(lp), 8'(v), 8'(lt)};
			hsv2rgb_pkg::SEC_C_B: {c.red, c.green, c.blue} = {8'(lp), 8'(lq), 8'(v)};
			hsv2rgb_pkg::SEC_B_M: {c.red, c.green, c.blue} = {8'(lt), 8'(lp), 8'(v)};
			default:              {c.red, c.green, c.blue} = {8'(v), 8'(lp), 8'(lq)};
		endcase
		return c;
	endfunction

	function automatic bit quiet_spell();
		return hsv_backlog.size() < 60 || (hsv_backlog.size() % 120) < 40;
	endfunction

	task automatic queue_pixel(int h, int s, int v, bit settle = 1'b0);
		hsv_job_t j;
		j.px.hue        = hsv2rgb_pkg::HUE_W'(h);
		j.px.saturation = hsv2rgb_pkg::LEVEL_W'(s);
		j.px.brightness = hsv2rgb_pkg::LEVEL_W'(v);
		j.settle        = settle;
		hsv_backlog.push_back(j);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (hsv_valid && hsv_ready)
				rgb_due.push_back(convert_pixel(hsv));
			if (!hsv_valid || hsv_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					hsv_valid <= 1'b0;
				end else if (hsv_backlog.size() > 0 &&
						!(hsv_backlog[0].settle && rgb_due.size() > 0)) begin
					job = hsv_backlog.pop_front();
					hsv       <= job.px;
					hsv_valid <= 1'b1;
					if (!quiet_spell() && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 15);
				end else begin
					hsv_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rgb_valid && rgb_ready) begin
				if (rgb_due.size() == 0) begin
					$display("%0t: rgb beat expected none got %h", $time, rgb);
					fail_count++;
				end else begin
					want = rgb_due.pop_front();
					if (rgb.red !== want.red) begin
						$display("%0t: red expected %0d got %0d", $time, want.red, rgb.red);
						fail_count++;
					end
					if (rgb.green !== want.green) begin
						$display("%0t: green expected %0d got %0d", $time, want.green,
							rgb.green);
						fail_count++;
					end
					if (rgb.blue !== want.blue) begin
						$display("%0t: blue expected %0d got %0d", $time, want.blue,
							rgb.blue);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rgb_ready <= 1'b0;
			end else begin
				rgb_ready <= 1'b1;
				if (!quiet_spell() && $urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 15);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int h, s, v;
		// sector boundaries, full turn wrap, grey, black and mid-sector mixes
		queue_pixel(0, 255, 255);
		queue_pixel(959, 255, 255);
		queue_pixel(960, 255, 255);
		queue_pixel(1919, 255, 255);
		queue_pixel(1920, 255, 255);
		queue_pixel(2880, 255, 255);
		queue_pixel(3839, 255, 255);
		queue_pixel(3840, 255, 255);
		queue_pixel(4800, 255, 255);
		queue_pixel(5759, 255, 255);
		queue_pixel(5760, 255, 255);
		queue_pixel(8191, 255, 255);
		queue_pixel(480, 0, 200);
		queue_pixel(3000, 0, 255);
		queue_pixel(1500, 255, 0);
		queue_pixel(8191, 0, 0);
		queue_pixel(480, 128, 77);
		queue_pixel(1440, 1, 254);
		queue_pixel(2400, 254, 1);
		queue_pixel(3360, 200, 100);
		queue_pixel(4320, 33, 190);
		queue_pixel(5280, 170, 250, 1'b1);
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			h = ($urandom_range(0, 7) == 0) ? $urandom_range(5760, 8191)
				: $urandom_range(0, 5759);
			case ($urandom_range(0, 9))
				0: s = 0;
				1: s = 255;
				default: s = $urandom_range(0, 255);
			endcase
			case ($urandom_range(0, 9))
				0: v = 0;
				1: v = 255;
				default: v = $urandom_range(0, 255);
			endcase
			queue_pixel(h, s, v, i == RANDOM_PIXELS / 2);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (hsv_backlog.size() > 0 || hsv_valid || rgb_due.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
